FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL of the grid scorer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Concurrent check that is switched off while reset is asserted.
`define PILG_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Concurrent check that also holds while reset is asserted.
`define PILG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PILG_ASSERT(lbl, clk, rst_n, prop, msg)
`define PILG_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: hdl/pilg_pkg.sv
// Types, constants and helper functions of the pairwise inbreeding grid scorer.
package pilg_pkg;

  localparam int unsigned LOCUS_W      = 12;
  localparam int unsigned GRID_IDX_W   = 4;
  localparam int unsigned CLASS_W      = 2;
  localparam int unsigned CALL_W       = 2;
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned SUM_W        = 48;
  localparam int unsigned CFG_W        = 5;
  localparam int unsigned CLASSES      = 3;
  localparam int unsigned MAX_OUT      = 16;
  localparam int unsigned LOCUS_SPAN   = 1 << LOCUS_W;

  localparam int unsigned GRID_POINTS_DEF = 16;
  localparam int unsigned LOCI_DEF        = 4096;
  localparam int unsigned ACC_WIDTH_DEF   = 48;

  localparam logic [CFG_W-1:0]  ACTIVE_RESET = 5'd16;
  localparam logic [WORD_W-1:0] NEG_INF_WORD = 32'h8000_0000;

  // Request codes.
  localparam logic REQ_TABLE_WRITE = 1'b0;
  localparam logic REQ_LOCUS       = 1'b1;

  // Call codes.
  localparam logic [CALL_W-1:0] CALL_MISSING = 2'd0;
  localparam logic [CALL_W-1:0] CALL_REF     = 2'd1;
  localparam logic [CALL_W-1:0] CALL_ALT     = 2'd2;

  // Genotype class codes.
  localparam logic [CLASS_W-1:0] CLS_BOTH_ALT = 2'd0;
  localparam logic [CLASS_W-1:0] CLS_BOTH_REF = 2'd1;
  localparam logic [CLASS_W-1:0] CLS_MIXED    = 2'd2;

  typedef struct packed {
    logic                     req_type;
    logic [LOCUS_W-1:0]       locus_index;
    logic [GRID_IDX_W-1:0]    grid_index;
    logic [CLASS_W-1:0]       genotype_class;
    logic signed [WORD_W-1:0] table_value;
    logic [CALL_W-1:0]        call_first;
    logic [CALL_W-1:0]        call_second;
    logic                     last_locus;
  } in_item_t;

  typedef struct packed {
    logic [GRID_IDX_W-1:0]   out_grid_index;
    logic signed [SUM_W-1:0] loglike_sum;
    logic [GRID_IDX_W-1:0]   best_index;
    logic                    saturated;
    logic                    last_result;
  } out_item_t;

  // Control that travels with one accumulator read into the update stage.
  typedef struct packed {
    logic                  vld;
    logic                  do_upd;
    logic                  first;
    logic [GRID_IDX_W-1:0] g;
  } stage_t;

  // Both alternate picks the both-alt class, both reference the both-ref
  // class, and anything else the mixed class.
  function automatic logic [CLASS_W-1:0] class_of(input logic [CALL_W-1:0] c1,
                                                  input logic [CALL_W-1:0] c2);
    logic [CLASS_W-1:0] k;
    if (c1 == CALL_ALT && c2 == CALL_ALT) begin
      k = CLS_BOTH_ALT;
    end else if (c1 == CALL_REF && c2 == CALL_REF) begin
      k = CLS_BOTH_REF;
    end else begin
      k = CLS_MIXED;
    end
    return k;
  endfunction

endpackage

FILE: hdl/pilg_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module pilg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/pilg_acc_unit.sv
// Saturating accumulator update and running best-index search.
module pilg_acc_unit #(
  parameter int unsigned ACC_WIDTH = pilg_pkg::ACC_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  pilg_pkg::stage_t                     stage_i,
  input  logic signed [ACC_WIDTH-1:0]          acc_i,
  input  logic                                 flag_i,
  input  logic signed [pilg_pkg::WORD_W-1:0]   word_i,
  output logic                                 we_o,
  output logic [pilg_pkg::GRID_IDX_W-1:0]      widx_o,
  output logic signed [ACC_WIDTH-1:0]          wacc_o,
  output logic                                 wflag_o,
  output logic [pilg_pkg::GRID_IDX_W-1:0]      best_idx_o
);

  localparam logic signed [ACC_WIDTH:0]   SUM_MAX = {2'b00, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH:0]   SUM_MIN = {2'b11, {(ACC_WIDTH-1){1'b0}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  logic signed [ACC_WIDTH:0]   sum;
  logic signed [ACC_WIDTH-1:0] new_acc;
  logic                        new_flag;
  logic signed [ACC_WIDTH-1:0] best_val_q, best_val_d;
  logic [pilg_pkg::GRID_IDX_W-1:0] best_idx_q, best_idx_d;

  assign sum = (ACC_WIDTH+1)'(acc_i) + (ACC_WIDTH+1)'(word_i);

  always_comb begin
    new_acc  = acc_i;
    new_flag = flag_i;
    if (stage_i.do_upd && !flag_i) begin
      if (word_i == pilg_pkg::NEG_INF_WORD) begin
        new_acc  = ACC_MIN;
        new_flag = 1'b1;
      end else if (sum > SUM_MAX) begin
        new_acc = ACC_MAX;
      end else if (word_i[pilg_pkg::WORD_W-1] && sum <= SUM_MIN) begin
        new_acc  = ACC_MIN;
        new_flag = 1'b1;
      end else begin
        new_acc = sum[ACC_WIDTH-1:0];
      end
    end
  end

  assign we_o    = stage_i.vld && stage_i.do_upd;
  assign widx_o  = stage_i.g;
  assign wacc_o  = new_acc;
  assign wflag_o = new_flag;

  // The first grid point seeds the search; later ones win only when strictly larger.
  always_comb begin
    best_val_d = best_val_q;
    best_idx_d = best_idx_q;
    if (stage_i.vld) begin
      if (stage_i.first || new_acc > best_val_q) begin
        best_val_d = new_acc;
        best_idx_d = stage_i.g;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_idx_q <= '0;
    end else begin
      best_idx_q <= best_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_val_q <= best_val_d;
  end

  assign best_idx_o = best_idx_q;

endmodule

FILE: hdl/pairwise_inbreeding_loglike_grid_core.sv
// Top level of the pairwise inbreeding log-likelihood grid scorer.
// This block scores one sample pair against a grid of up to sixteen inbreeding
// values. The host first loads the log-likelihood table through the input
// channel (table write items: one signed Q15.16 word per locus, grid point and
// genotype class; the word 0x80000000 means minus infinity), then streams the
// locus items of one pair. A locus item with a missing call adds nothing;
// otherwise its two calls pick a class and each active grid accumulator adds
// its table word, saturating at both limits; the low limit sets a sticky flag.
// On the item marked last, the block sends one result item per active grid
// point in ascending order, each with the first strictly best grid index, and
// then clears all accumulators. The table and the accumulators live in two
// synchronous RAMs; each grid point is read, updated and written back through
// a two-stage read-modify-write path, one grid point per cycle, so successive
// points never touch the same entry. A table write item passes the calc and
// write states; a locus item passes the calc state, one run state per active
// grid point (the accumulator RAM has a single read port) and the drain state;
// the last item of a pair then adds a read state and, per result item, a load
// and a hold state, which waits while the result stalls. The input channel
// stalls while an item is in progress. No clearing pass is needed after reset:
// per-entry valid bits make the accumulators read as zero. The active grid
// count register (reset 16) is written through the configuration channel,
// which is always ready; 0 counts as 1, values above the grid size clamp to it.
`include "assert_macros.svh"

module pairwise_inbreeding_loglike_grid_core #(
  parameter int unsigned GRID_POINTS = pilg_pkg::GRID_POINTS_DEF,
  parameter int unsigned LOCI        = pilg_pkg::LOCI_DEF,
  parameter int unsigned ACC_WIDTH   = pilg_pkg::ACC_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [pilg_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  pilg_pkg::in_item_t         in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output pilg_pkg::out_item_t        out_item_o
);

  // Grid indexes are four bits wide, so at most sixteen grid points are used,
  // and locus indexes are twelve bits wide.
  localparam int unsigned TBL_GRID  = (GRID_POINTS < pilg_pkg::MAX_OUT) ?
                                      GRID_POINTS : pilg_pkg::MAX_OUT;
  localparam int unsigned TBL_LOCI  = (LOCI < pilg_pkg::LOCUS_SPAN) ?
                                      LOCI : pilg_pkg::LOCUS_SPAN;
  localparam int unsigned ROW_WORDS = TBL_GRID * pilg_pkg::CLASSES;
  localparam int unsigned TBL_DEPTH = TBL_LOCI * ROW_WORDS;
  localparam int unsigned TAW       = $clog2(TBL_DEPTH);
  localparam int unsigned GW        = $clog2(TBL_GRID);
  localparam int unsigned GIW       = pilg_pkg::GRID_IDX_W;

  typedef enum logic [7:0] {
    ST_IDLE      = 8'b0000_0001,
    ST_CALC      = 8'b0000_0010,
    ST_WRITE     = 8'b0000_0100,
    ST_RUN       = 8'b0000_1000,
    ST_DRAIN     = 8'b0001_0000,
    ST_EMIT_RD   = 8'b0010_0000,
    ST_EMIT_LD   = 8'b0100_0000,
    ST_EMIT_HOLD = 8'b1000_0000
  } state_e;

  state_e                     state_q, state_d;
  pilg_pkg::in_item_t         item_q, item_d;
  logic [TAW-1:0]             addr_q, addr_d;
  logic [GIW-1:0]             g_q, g_d, g_inc;
  logic [GIW-1:0]             nm1_q, nm1_d;
  pilg_pkg::stage_t           p1_q, p1_d;
  logic                       out_valid_q, out_valid_d;
  pilg_pkg::out_item_t        out_q, out_d;
  logic [pilg_pkg::CFG_W-1:0] active_q;
  logic [TBL_GRID-1:0]        acc_vld_q;
  logic                       rd_vld_q;
  logic                       clr_vld;

  // Table RAM ports.
  logic                       tbl_we, tbl_re;
  logic [pilg_pkg::WORD_W-1:0] tbl_rdata;
  logic [TAW-1:0]             row_base, calc_off;

  // Accumulator RAM ports; each entry holds the flag above the sum.
  logic                       acc_re, acc_we;
  logic [GW-1:0]              acc_raddr;
  logic [ACC_WIDTH:0]         acc_rdata;
  logic [GIW-1:0]             acc_widx;
  logic signed [ACC_WIDTH-1:0] acc_wacc;
  logic                       acc_wflag;
  logic signed [ACC_WIDTH-1:0] rd_acc;
  logic                       rd_flag;
  logic [GIW-1:0]             best_idx;

  logic                       do_upd, wr_ok;
  logic [pilg_pkg::CLASS_W-1:0] cls_sel;

  // Configuration register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= pilg_pkg::ACTIVE_RESET;
    end else if (cfg_valid_i) begin
      active_q <= cfg_data_i;
    end
  end

  // Item decode.
  assign cls_sel = pilg_pkg::class_of(item_q.call_first, item_q.call_second);
  assign do_upd  = item_q.call_first != pilg_pkg::CALL_MISSING &&
                   item_q.call_second != pilg_pkg::CALL_MISSING &&
                   32'(item_q.locus_index) < LOCI;
  assign wr_ok   = 32'(item_q.locus_index) < LOCI &&
                   32'(item_q.grid_index) < TBL_GRID &&
                   32'(item_q.genotype_class) < pilg_pkg::CLASSES;

  // Table words of one locus form a row, grid point major, class minor.
  assign row_base = TAW'(32'(item_q.locus_index) * 32'(ROW_WORDS));
  assign calc_off = (item_q.req_type == pilg_pkg::REQ_TABLE_WRITE) ?
                    TAW'(32'(item_q.grid_index) * 32'(pilg_pkg::CLASSES) +
                         32'(item_q.genotype_class)) :
                    TAW'(cls_sel);

  assign g_inc = g_q + GIW'(1);

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    addr_d      = addr_q;
    g_d         = g_q;
    nm1_d       = nm1_q;
    p1_d        = '0;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    clr_vld     = 1'b0;
    acc_re      = 1'b0;
    acc_raddr   = g_q[GW-1:0];
    tbl_re      = 1'b0;
    tbl_we      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_item_i;
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        addr_d = row_base + calc_off;
        g_d    = '0;
        // A count of zero means one point; larger counts clamp to the grid.
        if (active_q == '0) begin
          nm1_d = '0;
        end else if (32'(active_q) > TBL_GRID) begin
          nm1_d = GIW'(TBL_GRID - 1);
        end else begin
          nm1_d = GIW'(active_q - pilg_pkg::CFG_W'(1));
        end
        state_d = (item_q.req_type == pilg_pkg::REQ_TABLE_WRITE) ? ST_WRITE : ST_RUN;
      end
      ST_WRITE: begin
        tbl_we  = wr_ok;
        state_d = ST_IDLE;
      end
      ST_RUN: begin
        // Issue both reads for grid point g; the update happens next cycle.
        acc_re      = 1'b1;
        tbl_re      = 1'b1;
        p1_d.vld    = 1'b1;
        p1_d.do_upd = do_upd;
        p1_d.first  = (g_q == '0);
        p1_d.g      = g_q;
        addr_d      = addr_q + TAW'(pilg_pkg::CLASSES);
        if (g_q == nm1_q) begin
          state_d = ST_DRAIN;
        end else begin
          g_d = g_inc;
        end
      end
      ST_DRAIN: begin
        g_d     = '0;
        state_d = item_q.last_locus ? ST_EMIT_RD : ST_IDLE;
      end
      ST_EMIT_RD: begin
        acc_re  = 1'b1;
        state_d = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        out_valid_d          = 1'b1;
        out_d.out_grid_index = g_q;
        out_d.loglike_sum    = pilg_pkg::SUM_W'(rd_acc);
        out_d.best_index     = best_idx;
        out_d.saturated      = rd_flag;
        out_d.last_result    = (g_q == nm1_q);
        state_d              = ST_EMIT_HOLD;
      end
      ST_EMIT_HOLD: begin
        if (!out_stall_i) begin
          out_valid_d = 1'b0;
          if (g_q == nm1_q) begin
            clr_vld = 1'b1;
            state_d = ST_IDLE;
          end else begin
            g_d       = g_inc;
            acc_re    = 1'b1;
            acc_raddr = g_inc[GW-1:0];
            state_d   = ST_EMIT_LD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      p1_q        <= '0;
      out_valid_q <= 1'b0;
      g_q         <= '0;
      nm1_q       <= '0;
      acc_vld_q   <= '0;
    end else begin
      state_q     <= state_d;
      p1_q        <= p1_d;
      out_valid_q <= out_valid_d;
      g_q         <= g_d;
      nm1_q       <= nm1_d;
      // Clearing the valid bits empties every accumulator at once.
      if (clr_vld) begin
        acc_vld_q <= '0;
      end else if (acc_we) begin
        acc_vld_q[acc_widx[GW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    addr_q <= addr_d;
    out_q  <= out_d;
    if (acc_re) begin
      rd_vld_q <= acc_vld_q[acc_raddr];
    end
  end

  pilg_ram #(
    .WIDTH (pilg_pkg::WORD_W),
    .DEPTH (TBL_DEPTH)
  ) u_table_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (addr_q),
    .wdata_i (item_q.table_value),
    .re_i    (tbl_re),
    .raddr_i (addr_q),
    .rdata_o (tbl_rdata)
  );

  pilg_ram #(
    .WIDTH (ACC_WIDTH + 1),
    .DEPTH (TBL_GRID)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_widx[GW-1:0]),
    .wdata_i ({acc_wflag, acc_wacc}),
    .re_i    (acc_re),
    .raddr_i (acc_raddr),
    .rdata_o (acc_rdata)
  );

  // An entry never written since the last clear reads as zero.
  assign rd_acc  = rd_vld_q ? acc_rdata[ACC_WIDTH-1:0] : '0;
  assign rd_flag = rd_vld_q & acc_rdata[ACC_WIDTH];

  pilg_acc_unit #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_acc_unit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stage_i    (p1_q),
    .acc_i      (rd_acc),
    .flag_i     (rd_flag),
    .word_i     (tbl_rdata),
    .we_o       (acc_we),
    .widx_o     (acc_widx),
    .wacc_o     (acc_wacc),
    .wflag_o    (acc_wflag),
    .best_idx_o (best_idx)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `PILG_ASSERT_ALWAYS(a_reset_idle, clk_i,
                      !rst_ni |=> state_q == ST_IDLE && !out_valid_o,
                      "block not idle in reset")
  `PILG_ASSERT(a_out_in_emit, clk_i, rst_ni,
               out_valid_o |-> state_q == ST_EMIT_HOLD,
               "result shown outside emit")
  `PILG_ASSERT(a_pipe_in_run, clk_i, rst_ni,
               p1_q.vld |-> (state_q == ST_RUN || state_q == ST_DRAIN),
               "update stage active outside a pass")
  `PILG_ASSERT(a_last_clears, clk_i, rst_ni,
               (out_valid_o && !out_stall_i && out_item_o.last_result) |=>
               (state_q == ST_IDLE && acc_vld_q == '0),
               "accumulators not cleared after last result")
  `PILG_ASSERT(a_best_range, clk_i, rst_ni,
               out_valid_o |-> (out_item_o.best_index <= nm1_q &&
                                out_item_o.out_grid_index <= nm1_q),
               "result index beyond active grid")

endmodule

FILE: tb/tb_pairwise_inbreeding_loglike_grid_core.sv
// Self-checking testbench for the pairwise inbreeding log-likelihood grid scorer.
`timescale 1ns / 100ps

module tb_pairwise_inbreeding_loglike_grid_core;
  import pilg_pkg::*;

  // Sizes of the block as instantiated with its default parameters.
  localparam int unsigned GRID_POINTS = GRID_POINTS_DEF;
  localparam int unsigned LOCI        = LOCI_DEF;
  localparam int unsigned ACC_BITS    = ACC_WIDTH_DEF;

  // Codes the package does not name.
  localparam logic [CALL_W-1:0]  CALL_OTHER  = 2'd3;
  localparam logic [CLASS_W-1:0] CLS_INVALID = 2'd3;

  localparam longint ACC_MAX = (longint'(1) << (ACC_BITS - 1)) - 1;
  localparam longint ACC_MIN = -ACC_MAX - 1;

  // The settle wait is long enough for the block to finish a locus item with all
  // sixteen grid points that gives no result.
  localparam int SETTLE_CYCLES   = 40;
  localparam int WATCHDOG_CYCLES = 2000;
  localparam int PHASE_ITEMS     = 40;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CFG_W-1:0]    cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_item_t            in_item_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_item_o;

  pairwise_inbreeding_loglike_grid_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Scoring model. It keeps its own copy of the table, the accumulators, the
  // sticky saturation flags and the active grid count, and turns each accepted
  // item into the result items the block has to send.
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0] loglike_words [LOCI * GRID_POINTS * CLASSES];
  longint            grid_sum      [GRID_POINTS];
  bit                grid_floored  [GRID_POINTS];
  logic [CFG_W-1:0]  active_setting = ACTIVE_RESET;
  out_item_t         expected_scores [$];

  function automatic int unsigned table_slot(logic [LOCUS_W-1:0] loc,
                                             logic [GRID_IDX_W-1:0] g,
                                             logic [CLASS_W-1:0] k);
    return (int'(loc) * GRID_POINTS + int'(g)) * CLASSES + int'(k);
  endfunction

  // Adds one table word to one accumulator. Minus infinity and any sum at or
  // below the negative limit pin the accumulator there until it is cleared;
  // a positive overflow clamps without setting the flag.
  function automatic void add_word(int g, logic [WORD_W-1:0] w);
    longint a;
    longint v;
    if (grid_floored[g]) return;
    if (w == NEG_INF_WORD) begin
      grid_sum[g]     = ACC_MIN;
      grid_floored[g] = 1'b1;
      return;
    end
    v = longint'($signed(w));
    a = grid_sum[g];
    if (v > 0 && a > ACC_MAX - v) begin
      a = ACC_MAX;
    end else if (v < 0 && a <= ACC_MIN - v) begin
      a = ACC_MIN;
      grid_floored[g] = 1'b1;
    end else begin
      a = a + v;
    end
    grid_sum[g] = a;
  endfunction

  function automatic void score_request(in_item_t rq);
    int               n;
    int               best;
    logic [CLASS_W-1:0] k;
    out_item_t        r;
    // A table write never gives a result, whatever its last flag says. Class 3
    // names no table entry and is dropped.
    if (rq.req_type == REQ_TABLE_WRITE) begin
      if (rq.genotype_class < CLASSES && rq.locus_index < LOCI && rq.grid_index < GRID_POINTS)
        loglike_words[table_slot(rq.locus_index, rq.grid_index, rq.genotype_class)] =
          rq.table_value;
      return;
    end
    // A register value of 0 counts as one grid point; large values clamp.
    n = int'(active_setting);
    if (n == 0) n = 1;
    if (n > GRID_POINTS) n = GRID_POINTS;
    if (n > MAX_OUT) n = MAX_OUT;
    // A missing call on either side leaves the accumulators alone.
    if (rq.call_first != CALL_MISSING && rq.call_second != CALL_MISSING &&
        rq.locus_index < LOCI) begin
      if (rq.call_first == CALL_ALT && rq.call_second == CALL_ALT) k = CLS_BOTH_ALT;
      else if (rq.call_first == CALL_REF && rq.call_second == CALL_REF) k = CLS_BOTH_REF;
      else k = CLS_MIXED;
      for (int g = 0; g < n; g++)
        add_word(g, loglike_words[table_slot(rq.locus_index, GRID_IDX_W'(g), k)]);
    end
    if (!rq.last_locus) return;
    // The best index moves only on a strictly greater sum, so ties keep the
    // lowest index.
    best = 0;
    for (int g = 1; g < n; g++)
      if (grid_sum[g] > grid_sum[best]) best = g;
    for (int g = 0; g < n; g++) begin
      r.out_grid_index = GRID_IDX_W'(g);
      r.loglike_sum    = grid_sum[g][SUM_W-1:0];
      r.best_index     = GRID_IDX_W'(best);
      r.saturated      = grid_floored[g];
      r.last_result    = (g == n - 1);
      expected_scores.push_back(r);
    end
    // Inactive points are cleared too.
    for (int g = 0; g < GRID_POINTS; g++) begin
      grid_sum[g]     = 0;
      grid_floored[g] = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking.
  // ---------------------------------------------------------------------------
  int mismatches = 0;

  function automatic void check_score(out_item_t got);
    out_item_t want;
    if (expected_scores.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result item: grid %0d sum %0d best %0d sat %0b last %0b",
                 got.out_grid_index, got.loglike_sum, got.best_index, got.saturated,
                 got.last_result);
      return;
    end
    want = expected_scores.pop_front();
    if (got.out_grid_index !== want.out_grid_index || got.loglike_sum !== want.loglike_sum ||
        got.best_index !== want.best_index || got.saturated !== want.saturated ||
        got.last_result !== want.last_result) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("result mismatch at %0t (expected / actual):", $realtime);
        $display("  grid %0d / %0d, sum %0d / %0d", want.out_grid_index, got.out_grid_index,
                 want.loglike_sum, got.loglike_sum);
        $display("  best %0d / %0d, sat %0b / %0b, last %0b / %0b", want.best_index,
                 got.best_index, want.saturated, got.saturated, want.last_result,
                 got.last_result);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Handshake sampling at the rising edge. The flags set here are read by the
  // drivers at the following falling edge, so no edge sees a half-updated
  // value. The watchdog ends the run when no channel moves for too long.
  // ---------------------------------------------------------------------------
  bit in_took;
  bit cfg_took;
  bit out_took;
  int requests_queued = 0;
  int requests_taken  = 0;
  int quiet_cycles    = 0;

  always @(posedge clk_i) begin
    in_took  = rst_ni && in_valid_i && !in_stall_o;
    cfg_took = rst_ni && cfg_valid_i && cfg_ready_o;
    out_took = rst_ni && out_valid_o && !out_stall_i;
    if (cfg_took) active_setting = cfg_data_i;
    if (in_took) begin
      score_request(in_item_i);
      requests_taken++;
    end
    if (out_took) check_score(out_item_o);
    if (in_took || cfg_took || out_took) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               quiet_cycles, expected_scores.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Idle patterns: mostly short gaps, now and then a long one. A calm flag
  // switches a side to full rate for a whole phase.
  // ---------------------------------------------------------------------------
  bit in_calm  = 1'b0;
  bit out_calm = 1'b0;

  function automatic int pick_gap(bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Request driver: presents the pending items in order at falling edges and
  // holds each one until the block has taken it.
  in_item_t request_q [$];
  int       request_gap = 0;

  always @(negedge clk_i) begin : drive_requests
    logic     nxt_valid;
    in_item_t nxt_item;
    nxt_valid = in_valid_i;
    nxt_item  = in_item_i;
    if (rst_ni && (!in_valid_i || in_took)) begin
      nxt_valid = 1'b0;
      if (request_gap > 0) begin
        request_gap--;
      end else if (request_q.size() > 0) begin
        nxt_item    = request_q.pop_front();
        nxt_valid   = 1'b1;
        request_gap = pick_gap(in_calm);
      end
    end
    in_valid_i <= nxt_valid;
    in_item_i  <= nxt_item;
  end

  // Result side back-pressure.
  int stall_left = 0;

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
      stall_left = pick_gap(out_calm);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus. The generator remembers which (locus, class) pairs have all
  // sixteen grid words loaded; observations with two calls only ever go to
  // those, so no unwritten table word is ever read.
  // ---------------------------------------------------------------------------
  bit combo_loaded [LOCUS_SPAN * CLASSES];
  int loaded_combos [$];
  int combo_loads = 0;

  logic [WORD_W-1:0] edge_words [7] = '{32'h0000_0000, 32'hFFFF_FFFF, NEG_INF_WORD,
                                        32'h8000_0001, 32'h7FFF_FFFF, 32'hFFFF_0000,
                                        32'h0000_0000};

  function automatic logic [WORD_W-1:0] rand_word();
    int unsigned       r;
    logic [WORD_W-1:0] w;
    r = $urandom_range(0, 99);
    w = $urandom();
    if (r < 4) w = NEG_INF_WORD;
    else if (r < 10) w = '0;
    else if (r < 16) w = '1;
    else if (r < 20) w = NEG_INF_WORD + 1;
    else if (r < 26) w[WORD_W-1] = 1'b0;
    else if (r < 30) w = 32'hFFFF_0000;
    else if (r < 34) w = 32'hFFFE_0000;
    else if (r < 60) w = {16'hFFFF, w[15:0]};
    else w[WORD_W-1] = 1'b1;
    return w;
  endfunction

  // Fields that an item of the other kind ignores carry random noise.
  function automatic in_item_t table_write(logic [LOCUS_W-1:0] loc, logic [GRID_IDX_W-1:0] g,
                                           logic [CLASS_W-1:0] k, logic [WORD_W-1:0] w);
    in_item_t rq;
    rq.req_type       = REQ_TABLE_WRITE;
    rq.locus_index    = loc;
    rq.grid_index     = g;
    rq.genotype_class = k;
    rq.table_value    = w;
    rq.call_first     = CALL_W'($urandom_range(0, 3));
    rq.call_second    = CALL_W'($urandom_range(0, 3));
    rq.last_locus     = 1'($urandom_range(0, 1));
    return rq;
  endfunction

  function automatic in_item_t locus_obs(logic [LOCUS_W-1:0] loc, logic [CALL_W-1:0] c1,
                                         logic [CALL_W-1:0] c2, bit last);
    in_item_t rq;
    rq.req_type       = REQ_LOCUS;
    rq.locus_index    = loc;
    rq.grid_index     = GRID_IDX_W'($urandom_range(0, 15));
    rq.genotype_class = CLASS_W'($urandom_range(0, 3));
    rq.table_value    = $urandom();
    rq.call_first     = c1;
    rq.call_second    = c2;
    rq.last_locus     = last;
    return rq;
  endfunction

  task automatic queue_request(in_item_t rq);
    request_q.push_back(rq);
    requests_queued++;
  endtask

  // Loads all grid words of one (locus, class) pair; the edge flag puts the
  // extreme table words on the low grid points.
  task automatic load_combo(logic [LOCUS_W-1:0] loc, logic [CLASS_W-1:0] k, bit edge_vals);
    int slot;
    slot = int'(loc) * CLASSES + int'(k);
    for (int g = 0; g < GRID_POINTS; g++)
      queue_request(table_write(loc, GRID_IDX_W'(g), k,
                                (edge_vals && g < 7) ? edge_words[g] : rand_word()));
    if (!combo_loaded[slot]) begin
      combo_loaded[slot] = 1'b1;
      loaded_combos.push_back(slot);
    end
    combo_loads++;
  endtask

  // One observation on a loaded pair. Most carry two calls that select the
  // class of the pair; the rest have a missing call on one or both sides.
  task automatic push_locus(bit last);
    int               slot;
    logic [LOCUS_W-1:0] loc;
    logic [CLASS_W-1:0] k;
    logic [CALL_W-1:0]  c1;
    logic [CALL_W-1:0]  c2;
    slot = loaded_combos[$urandom_range(0, loaded_combos.size() - 1)];
    loc  = LOCUS_W'(slot / CLASSES);
    k    = CLASS_W'(slot % CLASSES);
    if ($urandom_range(0, 99) < 12) begin
      c1 = CALL_W'($urandom_range(0, 3));
      c2 = CALL_W'($urandom_range(0, 3));
      if ($urandom_range(0, 1)) c1 = CALL_MISSING;
      else c2 = CALL_MISSING;
    end else if (k == CLS_BOTH_ALT) begin
      c1 = CALL_ALT;
      c2 = CALL_ALT;
    end else if (k == CLS_BOTH_REF) begin
      c1 = CALL_REF;
      c2 = CALL_REF;
    end else begin
      // Mixed: any pair of present calls except both ref and both alt.
      do begin
        c1 = CALL_W'($urandom_range(1, 3));
        c2 = CALL_W'($urandom_range(1, 3));
      end while (c1 == c2 && c1 != CALL_OTHER);
    end
    queue_request(locus_obs(loc, c1, c2, last));
  endtask

  // Waits until every item is taken and every result has arrived, then lets
  // the block finish any item that gives no result.
  task automatic drain_block();
    while (requests_taken != requests_queued || expected_scores.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_active(logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    do @(negedge clk_i); while (!cfg_took);
    cfg_valid_i <= 1'b0;
  endtask

  logic [CFG_W-1:0] phase_setting [9] = '{5'd0, 5'd1, 5'd31, 5'd16, 5'd17, 5'd8,
                                          5'd5, 5'd12, 5'd3};
  logic [LOCUS_W-1:0] seed_loci [3] = '{12'h000, 12'hAAA, 12'h555};

  initial begin : stimulus
    in_item_t rq;
    int       cnt;
    int       r;
    int       slot;
    logic [LOCUS_W-1:0] loc;
    logic [CLASS_W-1:0] k;

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part at the reset grid count of sixteen. The top locus gets the
    // extreme words: zero, minus one, minus infinity, the most negative finite
    // word, the largest positive word, minus one in Q15.16 and a second zero.
    load_combo(12'hFFF, CLS_MIXED, 1'b1);
    queue_request(locus_obs(12'hFFF, CALL_REF, CALL_ALT, 1'b0));
    queue_request(locus_obs(12'hFFF, CALL_OTHER, CALL_OTHER, 1'b0));
    queue_request(locus_obs(12'hFFF, CALL_MISSING, CALL_ALT, 1'b0));
    queue_request(locus_obs(12'hFFF, CALL_ALT, CALL_MISSING, 1'b0));
    queue_request(locus_obs(12'hFFF, CALL_OTHER, CALL_REF, 1'b1));
    // A class 3 write is dropped, and a last flag on a write gives no result.
    rq = table_write(12'hFFF, 4'd9, CLS_INVALID, 32'h0000_0000);
    rq.last_locus = 1'b1;
    queue_request(rq);
    rq = table_write(12'hFFF, 4'd15, CLS_MIXED, 32'hFFFF_0000);
    rq.last_locus = 1'b1;
    queue_request(rq);
    // A pair whose only locus is missing: every sum stays zero, all tie.
    queue_request(locus_obs(12'hFFF, CALL_MISSING, CALL_MISSING, 1'b1));
    drain_block();

    // Random phases, each with its own grid count and idle pattern.
    for (int ph = 0; ph < 9; ph++) begin
      in_calm  = (ph == 3 || ph == 6);
      out_calm = (ph == 5 || ph == 6);
      write_active((ph == 8) ? CFG_W'($urandom_range(0, 31)) : phase_setting[ph]);
      cnt = 0;
      while (cnt < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (loaded_combos.size() < 3 || (r < 8 && combo_loads < 12)) begin
          loc = (combo_loads <= 3) ? seed_loci[combo_loads - 1] : LOCUS_W'($urandom());
          k   = CLASS_W'($urandom_range(0, 2));
          load_combo(loc, k, 1'b0);
          cnt += GRID_POINTS;
        end else if (r < 30) begin
          // Table rewrites: mostly fresh words on loaded pairs, sometimes an
          // arbitrary address, class 3 included.
          if ($urandom_range(0, 99) < 70) begin
            slot = loaded_combos[$urandom_range(0, loaded_combos.size() - 1)];
            queue_request(table_write(LOCUS_W'(slot / CLASSES),
                                      GRID_IDX_W'($urandom_range(0, 15)),
                                      CLASS_W'(slot % CLASSES), rand_word()));
          end else begin
            queue_request(table_write(LOCUS_W'($urandom_range(0, 4095)),
                                      GRID_IDX_W'($urandom_range(0, 15)),
                                      CLASS_W'($urandom_range(0, 3)), rand_word()));
          end
          cnt++;
        end else begin
          push_locus($urandom_range(0, 5) == 0);
          cnt++;
        end
      end
      push_locus(1'b1);
      drain_block();
    end

    if (mismatches == 0 && expected_scores.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
